/* rtl/core/rwu_pkg.sv */
package rwu_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 32;
    localparam int MODE_W      = 2;
    localparam int THRESH_W    = 15;
    localparam int RATE_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = MAG_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int ROUND_SHIFT = 14;
    localparam int RND_W       = MUL_P_W - ROUND_SHIFT;
    localparam int DELTA_W     = RND_W + 1;
    localparam int SUM_W       = DELTA_W + 1;

    localparam logic [MUL_P_W-1:0] ROUND_BIAS = MUL_P_W'(1) << (ROUND_SHIFT - 1);

    localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
    localparam logic [THRESH_W-1:0] THRESH_RST = 15'd1280;
    localparam logic [RATE_W-1:0]   RATE_RST   = 16'd655;

    localparam logic [MODE_W-1:0] MODE_ONE_SIDED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYMMETRIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPPOSED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE   = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RND,
        S_ADD1,
        S_ADD2,
        S_WB
    } t_state;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [THRESH_W-1:0] threshold;
        logic [RATE_W-1:0]   rate;
    } t_cfg;

endpackage

/* rtl/core/rwu_if.sv */
interface rwu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rwu_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rwu_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rwu_pkg::WEIGHT_W-1:0]  weight_pos;
    logic signed [rwu_pkg::WEIGHT_W-1:0]  weight_neg;
    logic signed [rwu_pkg::SAMPLE_W-1:0]  reflex_value;
    logic                                 reflex_active;

    modport source (output valid, output weight_pos, output weight_neg,
                    output reflex_value, output reflex_active, input ready);
    modport sink   (input valid, input weight_pos, input weight_neg,
                    input reflex_value, input reflex_active, output ready);
endinterface

interface rwu_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rwu_pkg::CFG_IDX_W-1:0]        index;
    logic [rwu_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/reflex_weight_update_single_axis_core.sv */
// Channel   Modport  Payload                                           Role
// i_in      sink     sample                                            one tilt sample
// o_out     source   weight_pos, weight_neg, reflex_value, reflex_active  updated state
// i_cfg     sink     index, data                                       register writes
//
// Each transaction on i_in makes two passes through the shared multiplier,
// one rounding step and two passes through the shared saturating adder.
// The input is ready again once the result is in the output register.
// A stalled output holds the sequencer in its last step until the result is taken.
// Reset is synchronous and restores the weights, the reflex and the registers.
module reflex_weight_update_single_axis_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwu_in_if.sink     i_in,
    rwu_out_if.source  o_out,
    rwu_cfg_if.sink    i_cfg
);

    rwu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= rwu_pkg::MODE_RST;
            r_cfg.threshold <= rwu_pkg::THRESH_RST;
            r_cfg.rate      <= rwu_pkg::RATE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rwu_pkg::CFG_IDX_MODE:   r_cfg.mode      <= i_cfg.data[rwu_pkg::MODE_W-1:0];
                rwu_pkg::CFG_IDX_THRESH: r_cfg.threshold <= i_cfg.data[rwu_pkg::THRESH_W-1:0];
                rwu_pkg::CFG_IDX_RATE:   r_cfg.rate      <= i_cfg.data[rwu_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    rwu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/rwu_mul.sv */
module rwu_mul (
    input  logic                           i_clk,
    input  rwu_pkg::t_mul_req              i_req,
    output logic [rwu_pkg::MUL_P_W-1:0]    o_prod
);

    logic [rwu_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= rwu_pkg::MUL_P_W'(i_req.a) * rwu_pkg::MUL_P_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/rwu_sat_add.sv */
module rwu_sat_add (
    input  logic signed [rwu_pkg::WEIGHT_W-1:0] i_weight,
    input  logic signed [rwu_pkg::DELTA_W-1:0]  i_delta,
    input  rwu_pkg::t_op                        i_op,
    output logic signed [rwu_pkg::WEIGHT_W-1:0] o_sum
);

    localparam int SW = rwu_pkg::SUM_W;
    localparam int WW = rwu_pkg::WEIGHT_W;

    logic signed [SW-1:0] w_ext;
    logic signed [SW-1:0] d_ext;
    logic signed [SW-1:0] sum;

    always_comb begin
        w_ext = SW'(i_weight);
        d_ext = SW'(i_delta);
        case (i_op)
            rwu_pkg::OP_ADD: sum = w_ext + d_ext;
            rwu_pkg::OP_SUB: sum = w_ext - d_ext;
            default:         sum = w_ext;
        endcase
        if (sum[SW-1] && !(&sum[SW-2:WW-1])) begin
            o_sum = {1'b1, {(WW-1){1'b0}}};
        end else if (!sum[SW-1] && (|sum[SW-2:WW-1])) begin
            o_sum = {1'b0, {(WW-1){1'b1}}};
        end else begin
            o_sum = sum[WW-1:0];
        end
    end

endmodule

/* rtl/core/rwu_ctrl.sv */
module rwu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwu_pkg::t_cfg     i_cfg,
    rwu_in_if.sink            i_in,
    rwu_out_if.source         o_out
);

    localparam int SW = rwu_pkg::SAMPLE_W;
    localparam int MW = rwu_pkg::MAG_W;
    localparam int WW = rwu_pkg::WEIGHT_W;
    localparam int DW = rwu_pkg::DELTA_W;

    rwu_pkg::t_state r_state;
    rwu_pkg::t_state n_state;

    logic signed [SW-1:0]  r_sample;
    logic signed [SW-1:0]  r_last;
    logic [MW-1:0]         r_mag_s;
    logic [MW-1:0]         r_mag_d;
    logic                  r_neg;
    logic                  r_active;
    rwu_pkg::t_op          r_op_first;
    rwu_pkg::t_op          r_op_second;
    logic signed [DW-1:0]  r_delta;
    logic signed [WW-1:0]  r_w_first;
    logic signed [WW-1:0]  r_w_second;

    logic                  r_out_valid;
    logic signed [WW-1:0]  r_out_wpos;
    logic signed [WW-1:0]  r_out_wneg;
    logic signed [SW-1:0]  r_out_reflex;
    logic                  r_out_active;

    logic signed [MW-1:0]  s_ext;
    logic signed [MW-1:0]  th_ext;
    logic signed [MW-1:0]  diff;
    logic [MW-1:0]         mag_s;
    logic [MW-1:0]         mag_d;
    logic                  gt;
    logic                  lt;
    logic                  ge_mag;
    logic                  act;
    rwu_pkg::t_op          op_first;
    rwu_pkg::t_op          op_second;

    rwu_pkg::t_mul_req             mul_req;
    logic [rwu_pkg::MUL_P_W-1:0]   mul_prod;
    logic [rwu_pkg::MUL_P_W-1:0]   rnd_sum;
    logic [rwu_pkg::RND_W-1:0]     rnd_mag;

    logic signed [WW-1:0]  add_w;
    rwu_pkg::t_op          add_op;
    logic signed [WW-1:0]  add_sum;

    logic                  in_ready;
    logic                  out_load;

    rwu_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    rwu_sat_add u_sat_add (
        .i_weight (add_w),
        .i_delta  (r_delta),
        .i_op     (add_op),
        .o_sum    (add_sum)
    );

    // Threshold decision and difference are formed from the incoming sample.
    always_comb begin
        s_ext  = MW'(i_in.sample);
        th_ext = MW'(i_cfg.threshold);
        diff   = s_ext - MW'(r_last);
        mag_s  = s_ext[MW-1] ? MW'(-s_ext) : MW'(s_ext);
        mag_d  = diff[MW-1] ? MW'(-diff) : MW'(diff);
        gt     = s_ext > th_ext;
        lt     = s_ext < -th_ext;
        ge_mag = mag_s >= MW'(i_cfg.threshold);
        op_first  = rwu_pkg::OP_NONE;
        op_second = rwu_pkg::OP_NONE;
        act       = 1'b0;
        case (i_cfg.mode)
            rwu_pkg::MODE_SYMMETRIC: begin
                act = ge_mag;
                if (ge_mag) begin
                    op_first  = rwu_pkg::OP_ADD;
                    op_second = rwu_pkg::OP_SUB;
                end
            end
            rwu_pkg::MODE_OPPOSED: begin
                act = gt || lt;
                if (gt) begin
                    op_first  = rwu_pkg::OP_ADD;
                    op_second = rwu_pkg::OP_SUB;
                end else if (lt) begin
                    op_first  = rwu_pkg::OP_SUB;
                    op_second = rwu_pkg::OP_ADD;
                end
            end
            default: begin
                act = gt || lt;
                if (gt) begin
                    op_first = rwu_pkg::OP_ADD;
                end else if (lt) begin
                    op_second = rwu_pkg::OP_ADD;
                end
            end
        endcase
    end

    always_comb begin
        rnd_sum = mul_prod + rwu_pkg::ROUND_BIAS;
        rnd_mag = rnd_sum[rwu_pkg::MUL_P_W-1:rwu_pkg::ROUND_SHIFT];
    end

    always_comb begin
        case (r_state)
            rwu_pkg::S_IDLE: n_state = i_in.valid ? rwu_pkg::S_MUL1 : rwu_pkg::S_IDLE;
            rwu_pkg::S_MUL1: n_state = rwu_pkg::S_MUL2;
            rwu_pkg::S_MUL2: n_state = rwu_pkg::S_RND;
            rwu_pkg::S_RND:  n_state = rwu_pkg::S_ADD1;
            rwu_pkg::S_ADD1: n_state = rwu_pkg::S_ADD2;
            rwu_pkg::S_ADD2: n_state = rwu_pkg::S_WB;
            rwu_pkg::S_WB: begin
                n_state = (!r_out_valid || o_out.ready) ? rwu_pkg::S_IDLE : rwu_pkg::S_WB;
            end
            default:         n_state = rwu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        mul_req.en  = 1'b0;
        mul_req.a   = rwu_pkg::MUL_A_W'(r_mag_s);
        mul_req.b   = r_mag_d;
        add_w       = r_w_first;
        add_op      = r_op_first;
        case (r_state)
            rwu_pkg::S_IDLE: in_ready = 1'b1;
            rwu_pkg::S_MUL1: mul_req.en = 1'b1;
            rwu_pkg::S_MUL2: begin
                mul_req.en = 1'b1;
                mul_req.a  = mul_prod[rwu_pkg::MUL_A_W-1:0];
                mul_req.b  = rwu_pkg::MUL_B_W'(i_cfg.rate);
            end
            rwu_pkg::S_ADD2: begin
                add_w  = r_w_second;
                add_op = r_op_second;
            end
            rwu_pkg::S_WB:   out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_w_first   <= '0;
            r_w_second  <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == rwu_pkg::S_ADD1) begin
                r_w_first <= add_sum;
            end
            if (r_state == rwu_pkg::S_ADD2) begin
                r_w_second <= add_sum;
            end
            if (out_load) begin
                r_last <= r_active ? r_sample : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_sample    <= i_in.sample;
            r_mag_s     <= mag_s;
            r_mag_d     <= mag_d;
            r_neg       <= s_ext[MW-1] ^ diff[MW-1];
            r_active    <= act;
            r_op_first  <= op_first;
            r_op_second <= op_second;
        end
        if (r_state == rwu_pkg::S_RND) begin
            r_delta <= r_neg ? -DW'(rnd_mag) : DW'(rnd_mag);
        end
        if (out_load) begin
            r_out_wpos   <= r_w_first;
            r_out_wneg   <= r_w_second;
            r_out_reflex <= r_active ? r_sample : '0;
            r_out_active <= r_active;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.weight_pos    = r_out_wpos;
    assign o_out.weight_neg    = r_out_wneg;
    assign o_out.reflex_value  = r_out_reflex;
    assign o_out.reflex_active = r_out_active;

endmodule

/* verif/reflex_weight_update_single_axis_core_tb.sv */
`timescale 1ns / 100ps

module reflex_weight_update_single_axis_core_tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int ROUND_BITS = 14;
    localparam longint ROUND_HALF = 64'sd8192;
    localparam longint WEIGHT_MAX = 64'sd2147483647;
    localparam longint WEIGHT_MIN = -64'sd2147483648;
    localparam logic [rwu_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic signed [rwu_pkg::WEIGHT_W-1:0] w_pos;
        logic signed [rwu_pkg::WEIGHT_W-1:0] w_neg;
        logic signed [rwu_pkg::SAMPLE_W-1:0] reflex;
        logic                                active;
    } t_rule_result;

    class weight_rule_scoreboard;
        logic [rwu_pkg::MODE_W-1:0]          mode;
        logic [rwu_pkg::THRESH_W-1:0]        thresh;
        logic [rwu_pkg::RATE_W-1:0]          rate;
        logic signed [rwu_pkg::SAMPLE_W-1:0] last_reflex;
        logic signed [rwu_pkg::WEIGHT_W-1:0] w_first;
        logic signed [rwu_pkg::WEIGHT_W-1:0] w_second;
        t_rule_result                        expected_updates[$];
        int                                  mismatches;

        function new();
            mode = rwu_pkg::MODE_RST;
            thresh = rwu_pkg::THRESH_RST;
            rate = rwu_pkg::RATE_RST;
            last_reflex = '0;
            w_first = '0;
            w_second = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [rwu_pkg::CFG_IDX_W-1:0] idx,
                                     logic [rwu_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rwu_pkg::CFG_IDX_MODE: begin
                    mode = data[rwu_pkg::MODE_W-1:0];
                end
                rwu_pkg::CFG_IDX_THRESH: begin
                    thresh = data[rwu_pkg::THRESH_W-1:0];
                end
                rwu_pkg::CFG_IDX_RATE: begin
                    rate = data[rwu_pkg::RATE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic signed [rwu_pkg::WEIGHT_W-1:0] sat_add(
            logic signed [rwu_pkg::WEIGHT_W-1:0] w, longint d);
            longint total;
            total = longint'(w) + d;
            if (total > WEIGHT_MAX) return rwu_pkg::WEIGHT_W'(WEIGHT_MAX);
            if (total < WEIGHT_MIN) return rwu_pkg::WEIGHT_W'(WEIGHT_MIN);
            return rwu_pkg::WEIGHT_W'(total);
        endfunction

        function void note_sample(logic signed [rwu_pkg::SAMPLE_W-1:0] smp);
            longint       s;
            longint       th;
            longint       prod;
            longint       mag;
            longint       delta;
            logic         active;
            t_rule_result upd;
            s = longint'(smp);
            th = longint'(thresh);
            prod = s * (s - longint'(last_reflex)) * longint'(rate);
            mag = (prod < 0) ? -prod : prod;
            mag = (mag + ROUND_HALF) >>> ROUND_BITS;
            delta = (prod < 0) ? -mag : mag;
            case (mode)
                rwu_pkg::MODE_SYMMETRIC: begin
                    active = (((s < 0) ? -s : s) >= th);
                    if (active) begin
                        w_first = sat_add(w_first, delta);
                        w_second = sat_add(w_second, -delta);
                    end
                end
                rwu_pkg::MODE_OPPOSED: begin
                    active = (s > th) || (s < -th);
                    if (s > th) begin
                        w_first = sat_add(w_first, delta);
                        w_second = sat_add(w_second, -delta);
                    end else if (s < -th) begin
                        w_second = sat_add(w_second, delta);
                        w_first = sat_add(w_first, -delta);
                    end
                end
                default: begin
                    active = (s > th) || (s < -th);
                    if (s > th) begin
                        w_first = sat_add(w_first, delta);
                    end else if (s < -th) begin
                        w_second = sat_add(w_second, delta);
                    end
                end
            endcase
            last_reflex = active ? smp : '0;
            upd.w_pos = w_first;
            upd.w_neg = w_second;
            upd.reflex = last_reflex;
            upd.active = active;
            expected_updates.push_back(upd);
        endfunction

        function void compare_field(string what, logic signed [rwu_pkg::WEIGHT_W-1:0] want,
                                    logic signed [rwu_pkg::WEIGHT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(t_rule_result got);
            t_rule_result want;
            if (expected_updates.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, actual weight_pos %0d weight_neg %0d",
                         $time, got.w_pos, got.w_neg);
                return;
            end
            want = expected_updates.pop_front();
            compare_field("weight_pos", want.w_pos, got.w_pos);
            compare_field("weight_neg", want.w_neg, got.w_neg);
            compare_field("reflex_value", rwu_pkg::WEIGHT_W'(want.reflex),
                          rwu_pkg::WEIGHT_W'(got.reflex));
            compare_field("reflex_active", rwu_pkg::WEIGHT_W'(want.active),
                          rwu_pkg::WEIGHT_W'(got.active));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rwu_in_if  in_ch();
    rwu_out_if out_ch();
    rwu_cfg_if cfg_ch();

    weight_rule_scoreboard sb;
    t_rule_result          observed;
    bit                    no_gaps = 1'b0;
    bit                    in_raised = 1'b0;
    int                    sink_hold = 0;
    int                    idle_cycles = 0;

    reflex_weight_update_single_axis_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic signed [rwu_pkg::SAMPLE_W-1:0] pick_sample(int th);
        int v;
        case ($urandom_range(0, 5))
            0: v = th + int'($urandom_range(0, 2)) - 1;
            1: v = -th + int'($urandom_range(0, 2)) - 1;
            2: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            3: v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return rwu_pkg::SAMPLE_W'(v);
    endfunction

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            observed.w_pos = out_ch.weight_pos;
            observed.w_neg = out_ch.weight_neg;
            observed.reflex = out_ch.reflex_value;
            observed.active = out_ch.reflex_active;
            sb.check_result(observed);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [rwu_pkg::SAMPLE_W-1:0] smp);
        int gap;
        gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap != 0) begin
            if (in_raised) begin
                in_ch.valid <= 1'b0;
                in_raised = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= smp;
        in_raised = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_sample(smp);
    endtask

    task automatic release_input();
        if (in_raised) begin
            in_ch.valid <= 1'b0;
            in_raised = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.expected_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rwu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rwu_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_register(idx, data);
    endtask

    task automatic apply_config(input logic [rwu_pkg::CFG_DATA_W-1:0] mode_word,
                                input logic [rwu_pkg::CFG_DATA_W-1:0] th_word,
                                input logic [rwu_pkg::CFG_DATA_W-1:0] rate_word,
                                input bit poke_unused);
        write_reg(rwu_pkg::CFG_IDX_MODE, mode_word);
        write_reg(rwu_pkg::CFG_IDX_THRESH, th_word);
        write_reg(rwu_pkg::CFG_IDX_RATE, rate_word);
        if (poke_unused) write_reg(CFG_IDX_UNUSED, rwu_pkg::CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        release_input();
        wait_drained();
    endtask

    initial begin
        logic [rwu_pkg::CFG_DATA_W-1:0] mode_word;
        logic [rwu_pkg::CFG_DATA_W-1:0] th_word;
        logic [rwu_pkg::CFG_DATA_W-1:0] rate_word;
        int                             phase_th;

        sb = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register values after reset, threshold edges and sample extremes.
        send_sample(16'sd0);
        send_sample(16'sd1281);
        send_sample(16'sd1280);
        send_sample(-16'sd1281);
        send_sample(-16'sd1280);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);

        // Symmetric rule at zero threshold and full rate, then saturation.
        settle();
        apply_config(16'hFFFD, 16'h8000, 16'hFFFF, 1'b1);
        send_sample(16'sd0);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd5);
        send_sample(-16'sd5);

        settle();
        apply_config(16'h0002, 16'h0000, 16'h8001, 1'b0);
        send_sample(16'sd0);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);

        // The unused mode code with the largest threshold and zero rate.
        settle();
        apply_config(16'h0003, 16'hFFFF, 16'h0000, 1'b0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);

        // Products, some of which land exactly halfway between two output steps.
        settle();
        apply_config(16'hFFFC, 16'h0000, 16'h0001, 1'b0);
        send_sample(16'sd288);
        send_sample(16'sd32);
        send_sample(-16'sd64);
        send_sample(16'sd64);

        for (int p = 0; p < 10; p++) begin
            settle();
            no_gaps = (p % 4 == 3);
            mode_word = rwu_pkg::CFG_DATA_W'($urandom);
            th_word = rwu_pkg::CFG_DATA_W'($urandom);
            case ($urandom_range(0, 4))
                0: th_word[rwu_pkg::THRESH_W-1:0] = '0;
                1: th_word[rwu_pkg::THRESH_W-1:0] = '1;
                2: th_word[rwu_pkg::THRESH_W-1:0] = rwu_pkg::THRESH_W'($urandom_range(0, 255));
                default: begin
                    th_word[rwu_pkg::THRESH_W-1:0] = rwu_pkg::THRESH_W'($urandom_range(0, 32767));
                end
            endcase
            case ($urandom_range(0, 4))
                0: rate_word = '0;
                1: rate_word = '1;
                2: rate_word = rwu_pkg::CFG_DATA_W'($urandom_range(1, 1023));
                default: rate_word = rwu_pkg::CFG_DATA_W'($urandom);
            endcase
            phase_th = int'(th_word[rwu_pkg::THRESH_W-1:0]);
            apply_config(mode_word, th_word, rate_word, $urandom_range(0, 1) != 0);
            for (int i = 0; i < 48; i++) begin
                if (p == 2 && i == 24) settle();
                send_sample(pick_sample(phase_th));
            end
        end

        no_gaps = 1'b0;
        settle();
        repeat (20) @(posedge i_clk);
        if (sb.expected_updates.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_updates.size());
        end
        if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
